// ----- sv/double_ended_queue_defines.svh -----
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define DQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/dq_pkg.sv -----
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = AW + 2;
  localparam int DW    = 32;
  localparam int OCC_W = 5;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  typedef enum logic [1:0] {
    FN_PUSH_FRONT,
    FN_PUSH_BACK,
    FN_POP_FRONT,
    FN_POP_BACK
  } dq_func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL
  } dq_status_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } dq_state_t;

  typedef struct packed {
    logic exec;
  } dq_cmd_t;

  function automatic logic [AW-1:0] dq_wrap(input logic [AW:0] base, input logic [AW:0] off);
    logic [SW-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// ----- sv/dq_if.sv -----
`timescale 1ns / 1ps
interface dq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [31:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

interface dq_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] popped_value;
  logic [1:0]        status;
  logic [4:0]        occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input popped_value, input status, input occupancy,
                output ready);
endinterface

// ----- sv/dq_ctrl.sv -----
`timescale 1ns / 1ps
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  dq_state_t state_r;
  dq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_valid = 1'b0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.exec = in_valid && in_ready;
    if (cmd.exec) begin
      state_nxt = S_RESP;
    end else if (out_valid && out_ready) begin
      state_nxt = S_IDLE;
    end
  end

endmodule

// ----- sv/dq_datapath.sv -----
`timescale 1ns / 1ps
module dq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dq_pkg::dq_cmd_t                 cmd,
  input  logic [1:0]                      func,
  input  logic signed [dq_pkg::DW-1:0]    push_value,
  output logic signed [dq_pkg::DW-1:0]    popped_value,
  output logic [1:0]                      status,
  output logic [dq_pkg::OCC_W-1:0]        occupancy
);
  import dq_pkg::*;

  logic [DW-1:0]    mem [DEPTH];
  logic [DW-1:0]    rdata_r;
  logic [AW-1:0]    front_r;
  logic [AW-1:0]    front_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             pop_ok_r;
  dq_status_t       status_r;
  dq_status_t       status_nxt;
  logic [OCC_W-1:0] occ_r;

  logic             full;
  logic             empty;
  logic             we;
  logic             re;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    back_push;
  logic [AW-1:0]    back_pop;
  logic [AW-1:0]    front_inc;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign back_push = dq_wrap({1'b0, front_r}, (AW + 1)'(count_r));
  assign back_pop  = dq_wrap({1'b0, front_r}, (AW + 1)'(count_r - 1'b1));
  assign front_inc = dq_wrap({1'b0, front_r}, (AW + 1)'(1));

  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    waddr      = back_push;
    raddr      = front_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    case (dq_func_t'(func))
      FN_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          waddr     = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          waddr     = back_push;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re        = 1'b1;
          raddr     = front_r;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          re        = 1'b1;
          raddr     = back_pop;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= push_value;
    end
    if (cmd.exec && re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_r <= re;
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign popped_value = pop_ok_r ? rdata_r : '0;
  assign status       = status_r;
  assign occupancy    = occ_r;

endmodule

// ----- sv/double_ended_queue.sv -----
// The result of an operation is valid in the cycle after its input transfer.
// Throughput: one operation per cycle while the result side keeps taking results;
// the single result register and the one-port store set this rate.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// the entry store itself is not cleared.
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"
module double_ended_queue (
  input logic      clk,
  input logic      rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  dq_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .func         (in_ch.func),
    .push_value   (in_ch.push_value),
    .popped_value (out_ch.popped_value),
    .status       (out_ch.status),
    .occupancy    (out_ch.occupancy)
  );

  `DQ_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_ch.valid && in_ch.ready, out_ch.valid)
  `DQ_ASSERT_NEXT(a_result_drains, clk, rst_n, out_ch.valid && out_ch.ready && !(in_ch.valid && in_ch.ready), !out_ch.valid)
  `DQ_ASSERT_IMPLY(a_full_occupancy, clk, rst_n, out_ch.valid && out_ch.status == ST_FULL, out_ch.occupancy == FULL_OCC)
  `DQ_ASSERT_IMPLY(a_refused_zero, clk, rst_n, out_ch.valid && (out_ch.status == ST_EMPTY || out_ch.status == ST_FULL), out_ch.popped_value == '0)

endmodule
